>>> hw/rtl/msp_pkg.sv
// Shared types and constants for the message set parser.
`timescale 1ns / 1ps

package msp_pkg;

  // Report status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CRC_BAD   = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_BAD_KEY   = 3'd3,
    ST_BAD_VALUE = 3'd4,
    ST_TRUNC     = 3'd5,
    ST_NONE      = 3'd6
  } status_e;

  // Compression code for attribute bytes above the known codecs
  localparam logic [2:0] CMP_UNKNOWN = 3'd4;
  localparam logic [7:0] CMP_MAX_KNOWN = 8'd3;

  // Smallest legal body: crc, magic, attributes, key length, value length
  localparam logic [31:0] MIN_BODY = 32'd14;
  // Distance from message start to the first key byte
  localparam logic [31:0] KEY_HDR = 32'd22;
  // Key header plus the value length field
  localparam logic [31:0] VALUE_HDR = 32'd26;

  // Raw report from the parser, finished by the formatter
  typedef struct packed {
    status_e     status;
    logic        set_end;
    logic [23:0] msg_head;
    logic [31:0] size;
    logic [7:0]  attr;
    logic [31:0] key_len;
    logic [31:0] val_len;
  } report_t;

endpackage

>>> hw/rtl/message_set_parser_crc_check.sv
// Top level of the message set parser: input register, report register, wiring.
// A report passes the input register, then the report register (parse), then the output
//   register (format) before it is valid on the outputs.
// Throughput: 1 byte per cycle; input stall rises only when all three stages hold data
//   and the output is stalled.
// Reset: rst_ni clears all stage valids and returns the parse state to the start of a set.
`timescale 1ns / 1ps

module message_set_parser_crc_check #(
  parameter longint unsigned MAX_SET_BYTES = 64'd16777216
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        set_end_o,
  output logic [23:0] message_offset_o,
  output logic [23:0] message_size_o,
  output logic [23:0] key_offset_o,
  output logic [23:0] key_length_o,
  output logic [23:0] value_offset_o,
  output logic [23:0] value_length_o,
  output logic [2:0]  compression_o
);
  import msp_pkg::*;

  localparam logic [23:0] PosLimit =
    (MAX_SET_BYTES > 64'd16777216) ? 24'hFFFFFF : 24'(MAX_SET_BYTES - 64'd1);

  logic        a_vld_q;
  logic [7:0]  a_byte_q;
  logic        a_last_q;
  logic        a_go;
  logic        b_vld_q;
  report_t     b_rpt_q;
  logic        b_ready;
  logic        c_ready;
  logic        emit;
  report_t     rpt;

  assign b_ready    = !b_vld_q || c_ready;
  assign a_go       = a_vld_q && b_ready;
  assign in_stall_o = a_vld_q && !b_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      a_vld_q <= 1'b1;
    end else if (a_go) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      a_byte_q <= data_byte_i;
      a_last_q <= last_byte_i;
    end
  end

  msp_parser #(
    .POS_LIMIT(PosLimit)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (a_go),
    .data_byte_i (a_byte_q),
    .last_byte_i (a_last_q),
    .emit_o      (emit),
    .report_o    (rpt)
  );

  // Report register between parse and format
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_ready) begin
      b_vld_q <= a_go && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_rpt_q <= rpt;
    end
  end

  msp_format #(
    .POS_LIMIT(PosLimit)
  ) u_format (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (b_vld_q && c_ready),
    .report_i         (b_rpt_q),
    .out_stall_i      (out_stall_i),
    .ready_o          (c_ready),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .set_end_o        (set_end_o),
    .message_offset_o (message_offset_o),
    .message_size_o   (message_size_o),
    .key_offset_o     (key_offset_o),
    .key_length_o     (key_length_o),
    .value_offset_o   (value_offset_o),
    .value_length_o   (value_length_o),
    .compression_o    (compression_o)
  );

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (a_vld_q && b_vld_q && out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipeline");

  a_close_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_TRUNC || status_o == ST_NONE)) |-> set_end_o)
    else $error("closing report without set end");

  a_value_after_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |-> (value_offset_o >= key_offset_o))
    else $error("value placed before key");

endmodule

>>> hw/rtl/msp_parser.sv
// Byte-wide message set parse state, CRC update and report decision.
`timescale 1ns / 1ps

module msp_parser #(
  parameter logic [23:0] POS_LIMIT = 24'hFFFFFF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             emit_o,
  output msp_pkg::report_t report_o
);
  import msp_pkg::*;

  typedef enum logic [8:0] {
    PH_OFFSET = 9'b000000001,
    PH_SIZE   = 9'b000000010,
    PH_CRC    = 9'b000000100,
    PH_MAGIC  = 9'b000001000,
    PH_ATTR   = 9'b000010000,
    PH_KLEN   = 9'b000100000,
    PH_KEY    = 9'b001000000,
    PH_VLEN   = 9'b010000000,
    PH_REST   = 9'b100000000
  } phase_e;

  localparam logic [2:0] CntLast8 = 3'd7;
  localparam logic [2:0] CntLast4 = 3'd3;

  // Reflected CRC-32 over one byte, one bit per step
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'd0);
    end
    return c;
  endfunction

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [23:0] pos_q, pos_d;
  logic [23:0] ms_q, ms_d;
  logic [31:0] size_q, size_d;
  logic [30:0] left_q, left_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] exp_q, exp_d;
  logic [7:0]  attr_q, attr_d;
  logic [31:0] klen_q, klen_d;
  logic [31:0] vlen_q, vlen_d;
  logic        disc_q, disc_d;
  logic        kbad_q, kbad_d;
  logic [30:0] vtgt_q, vtgt_d;
  logic [30:0] kleft_q, kleft_d;

  logic [31:0] crc_next;
  logic [31:0] size_nxt;
  logic [31:0] klen_nxt;
  logic [31:0] vlen_nxt;
  logic [31:0] vlen_cur;
  logic [30:0] k_map;
  logic        k_neg;
  logic        k_over;
  logic        crc_ok;
  logic        len_bad;
  logic        emit;
  logic        err;
  report_t     rpt;

  // Field shifts, CRC and the checks that feed the end-of-message decision
  assign crc_next = crc32_byte(crc_q, data_byte_i);
  assign size_nxt = {size_q[23:0], data_byte_i};
  assign klen_nxt = {klen_q[23:0], data_byte_i};
  assign vlen_nxt = {vlen_q[23:0], data_byte_i};
  assign vlen_cur = (phase_q == PH_VLEN) ? vlen_nxt : vlen_q;
  assign k_map    = (klen_nxt == '1) ? 31'd0 : klen_nxt[30:0];
  assign k_neg    = klen_nxt[31] && (klen_nxt != '1);
  assign k_over   = ({1'b0, k_map} + MIN_BODY) > size_q;
  assign crc_ok   = (~crc_next == exp_q);
  assign len_bad  = (vlen_cur == '1) ? (vtgt_q != 31'd0) : (vlen_cur != {1'b0, vtgt_q});

  // Next state and report for the current byte
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    ms_d    = ms_q;
    size_d  = size_q;
    left_d  = left_q;
    crc_d   = crc_q;
    exp_d   = exp_q;
    attr_d  = attr_q;
    klen_d  = klen_q;
    vlen_d  = vlen_q;
    disc_d  = disc_q;
    kbad_d  = kbad_q;
    vtgt_d  = vtgt_q;
    kleft_d = kleft_q;
    emit    = 1'b0;
    err     = 1'b0;
    rpt     = '0;

    if (disc_q) begin
      // Drop bytes until the set closes
      if (last_byte_i) begin
        emit       = 1'b1;
        rpt.status = ST_NONE;
      end
    end else begin
      case (phase_q)
        PH_OFFSET: begin
          if (cnt_q == 3'd0) begin
            ms_d = pos_q;
          end
          if (cnt_q == CntLast8) begin
            phase_d = PH_SIZE;
            cnt_d   = 3'd0;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_SIZE: begin
          size_d = size_nxt;
          if (cnt_q == CntLast4) begin
            cnt_d = 3'd0;
            if (size_nxt[31] || (size_nxt < MIN_BODY)) begin
              emit         = 1'b1;
              err          = 1'b1;
              rpt.status   = ST_BAD_SIZE;
              rpt.msg_head = ms_q;
              rpt.size     = size_nxt;
            end else begin
              left_d  = size_nxt[30:0];
              crc_d   = '1;
              phase_d = PH_CRC;
            end
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        default: begin
          // Body byte: count down and fold into the CRC (the CRC field bytes are not folded)
          left_d = left_q - 31'd1;
          if (phase_q != PH_CRC) begin
            crc_d = crc_next;
          end
          case (phase_q)
            PH_CRC: begin
              exp_d = {exp_q[23:0], data_byte_i};
              if (cnt_q == CntLast4) begin
                cnt_d   = 3'd0;
                phase_d = PH_MAGIC;
              end else begin
                cnt_d = cnt_q + 3'd1;
              end
            end
            PH_MAGIC: begin
              phase_d = PH_ATTR;
            end
            PH_ATTR: begin
              attr_d  = data_byte_i;
              phase_d = PH_KLEN;
            end
            PH_KLEN: begin
              klen_d = klen_nxt;
              if (cnt_q == CntLast4) begin
                cnt_d   = 3'd0;
                kbad_d  = k_neg || k_over;
                vtgt_d  = 31'(size_q - MIN_BODY - {1'b0, k_map});
                kleft_d = k_map;
                if (k_neg || k_over) begin
                  phase_d = PH_REST;
                end else if (k_map == 31'd0) begin
                  phase_d = PH_VLEN;
                end else begin
                  phase_d = PH_KEY;
                end
              end else begin
                cnt_d = cnt_q + 3'd1;
              end
            end
            PH_KEY: begin
              kleft_d = kleft_q - 31'd1;
              if (kleft_q == 31'd1) begin
                phase_d = PH_VLEN;
              end
            end
            PH_VLEN: begin
              vlen_d = vlen_nxt;
              if (cnt_q == CntLast4) begin
                cnt_d   = 3'd0;
                phase_d = PH_REST;
              end else begin
                cnt_d = cnt_q + 3'd1;
              end
            end
            default: begin
            end
          endcase

          // Close the message on its last body byte
          if (left_d == 31'd0) begin
            emit         = 1'b1;
            rpt.msg_head = ms_q;
            rpt.size     = size_q;
            rpt.attr     = attr_q;
            rpt.key_len  = klen_q;
            rpt.val_len  = vlen_cur;
            if (!crc_ok) begin
              rpt.status = ST_CRC_BAD;
            end else if (kbad_q) begin
              rpt.status = ST_BAD_KEY;
              err        = 1'b1;
            end else if (len_bad) begin
              rpt.status = ST_BAD_VALUE;
              err        = 1'b1;
            end else begin
              rpt.status = ST_OK;
            end
            phase_d = PH_OFFSET;
            cnt_d   = 3'd0;
            size_d  = '0;
            exp_d   = '0;
            klen_d  = '0;
            vlen_d  = '0;
            attr_d  = '0;
          end
        end
      endcase

      // Set ends inside a message
      if (last_byte_i && !emit) begin
        emit         = 1'b1;
        rpt.status   = ST_TRUNC;
        rpt.msg_head = ms_d;
        rpt.size     = (phase_d == PH_OFFSET || phase_d == PH_SIZE) ? 32'd0 : size_d;
      end
    end

    if (err) begin
      disc_d = 1'b1;
    end

    // Return to reset values after the set's last byte
    if (last_byte_i) begin
      rpt.set_end = 1'b1;
      phase_d = PH_OFFSET;
      cnt_d   = 3'd0;
      pos_d   = '0;
      ms_d    = '0;
      size_d  = '0;
      left_d  = '0;
      crc_d   = '1;
      exp_d   = '0;
      attr_d  = '0;
      klen_d  = '0;
      vlen_d  = '0;
      disc_d  = 1'b0;
      kbad_d  = 1'b0;
      vtgt_d  = '0;
      kleft_d = '0;
    end else if (pos_q != POS_LIMIT) begin
      pos_d = pos_q + 24'd1;
    end
  end

  assign emit_o   = emit;
  assign report_o = rpt;

  // Advance parse state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OFFSET;
      cnt_q   <= '0;
      pos_q   <= '0;
      ms_q    <= '0;
      size_q  <= '0;
      left_q  <= '0;
      crc_q   <= '1;
      exp_q   <= '0;
      attr_q  <= '0;
      klen_q  <= '0;
      vlen_q  <= '0;
      disc_q  <= 1'b0;
      kbad_q  <= 1'b0;
      vtgt_q  <= '0;
      kleft_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      ms_q    <= ms_d;
      size_q  <= size_d;
      left_q  <= left_d;
      crc_q   <= crc_d;
      exp_q   <= exp_d;
      attr_q  <= attr_d;
      klen_q  <= klen_d;
      vlen_q  <= vlen_d;
      disc_q  <= disc_d;
      kbad_q  <= kbad_d;
      vtgt_q  <= vtgt_d;
      kleft_q <= kleft_d;
    end
  end

  a_disc_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && disc_q && !last_byte_i) |-> !emit_o)
    else $error("report raised while dropping bytes");

  a_set_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_byte_i) |=> (pos_q == '0 && !disc_q && phase_q == PH_OFFSET))
    else $error("parse state not cleared after set end");

  a_size_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && emit_o && report_o.status == ST_BAD_SIZE && !last_byte_i) |=> disc_q)
    else $error("bad size did not start dropping");

endmodule

>>> hw/rtl/msp_format.sv
// Report formatting (clamps, key and value positions) and the output register.
`timescale 1ns / 1ps

module msp_format #(
  parameter logic [23:0] POS_LIMIT = 24'hFFFFFF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  msp_pkg::report_t report_i,
  input  logic             out_stall_i,
  output logic             ready_o,
  output logic             out_valid_o,
  output logic [2:0]       status_o,
  output logic             set_end_o,
  output logic [23:0]      message_offset_o,
  output logic [23:0]      message_size_o,
  output logic [23:0]      key_offset_o,
  output logic [23:0]      key_length_o,
  output logic [23:0]      value_offset_o,
  output logic [23:0]      value_length_o,
  output logic [2:0]       compression_o
);
  import msp_pkg::*;

  // Saturate a position or count at the limit
  function automatic logic [23:0] clamp_pos(input logic [31:0] v);
    return (v > {8'd0, POS_LIMIT}) ? POS_LIMIT : v[23:0];
  endfunction

  logic [30:0] k_map;
  logic [30:0] v_map;
  logic [23:0] size_shown;
  logic [23:0] key_off;
  logic [23:0] key_cnt;
  logic [23:0] val_off;
  logic [23:0] val_cnt;
  logic [2:0]  cmp;

  logic        vld_q;
  logic [2:0]  status_q, status_d;
  logic        set_end_q;
  logic [23:0] msg_off_q;
  logic [23:0] msg_size_q, msg_size_d;
  logic [23:0] key_off_q, key_off_d;
  logic [23:0] key_len_q, key_len_d;
  logic [23:0] val_off_q, val_off_d;
  logic [23:0] val_len_q, val_len_d;
  logic [2:0]  cmp_q, cmp_d;

  // Map the -1 length and derive the positions
  assign k_map      = (report_i.key_len == '1) ? 31'd0 : report_i.key_len[30:0];
  assign v_map      = (report_i.val_len == '1) ? 31'd0 : report_i.val_len[30:0];
  assign size_shown = report_i.size[31] ? 24'd0 : clamp_pos(report_i.size);
  assign key_off    = clamp_pos({8'd0, report_i.msg_head} + KEY_HDR);
  assign key_cnt    = clamp_pos({1'b0, k_map});
  assign val_off    = clamp_pos({8'd0, report_i.msg_head} + {1'b0, k_map} + VALUE_HDR);
  assign val_cnt    = clamp_pos({1'b0, v_map});
  assign cmp        = (report_i.attr <= CMP_MAX_KNOWN) ? report_i.attr[2:0] : CMP_UNKNOWN;

  // Select which fields each status shows
  always_comb begin
    status_d   = report_i.status;
    msg_size_d = size_shown;
    key_off_d  = '0;
    key_len_d  = '0;
    val_off_d  = '0;
    val_len_d  = '0;
    cmp_d      = '0;
    case (report_i.status)
      ST_OK: begin
        key_off_d = key_off;
        key_len_d = key_cnt;
        val_off_d = val_off;
        val_len_d = val_cnt;
        cmp_d     = cmp;
      end
      ST_BAD_VALUE: begin
        key_off_d = key_off;
        key_len_d = key_cnt;
        cmp_d     = cmp;
      end
      ST_CRC_BAD, ST_BAD_KEY: begin
        cmp_d = cmp;
      end
      default: begin
      end
    endcase
  end

  assign ready_o = !vld_q || !out_stall_i;

  // Hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q   <= status_d;
      set_end_q  <= report_i.set_end;
      msg_off_q  <= report_i.msg_head;
      msg_size_q <= msg_size_d;
      key_off_q  <= key_off_d;
      key_len_q  <= key_len_d;
      val_off_q  <= val_off_d;
      val_len_q  <= val_len_d;
      cmp_q      <= cmp_d;
    end
  end

  assign out_valid_o      = vld_q;
  assign status_o         = status_q;
  assign set_end_o        = set_end_q;
  assign message_offset_o = msg_off_q;
  assign message_size_o   = msg_size_q;
  assign key_offset_o     = key_off_q;
  assign key_length_o     = key_len_q;
  assign value_offset_o   = val_off_q;
  assign value_length_o   = val_len_q;
  assign compression_o    = cmp_q;

endmodule
